// File: sv/rbst_pkg.sv
// Shared types and constants for the ray versus box slab test.
// Used by every module of the block; depends on nothing else.
package rbst_pkg;

    // Bits of a Q16.16 coordinate and of the scaled slab numerator.
    localparam int unsigned COORD_W = 32;
    localparam int unsigned NUM_W   = 49;

    // Divider latency: one prepare stage, one stage per quotient bit, one saturate stage.
    localparam int unsigned DIV_LAT  = NUM_W + 2;
    // Axis lane latency: divider plus the entry/exit ordering register.
    localparam int unsigned AXIS_LAT = DIV_LAT + 1;
    // Start to done: axis lanes plus the merge register.
    localparam int unsigned TOP_LAT  = AXIS_LAT + 1;

    // Saturation limits of the Q16.16 range.
    localparam logic [COORD_W-1:0] SAT_HI = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] SAT_LO = 32'h8000_0000;

    // Slab result of one axis lane.
    typedef struct packed {
        logic                        bounded;  // direction nonzero, entry/exit valid
        logic                        outside;  // zero direction and origin outside slab
        logic signed [COORD_W-1:0]   t_entry;
        logic signed [COORD_W-1:0]   t_exit;
    } axis_res_t;

endpackage

// File: sv/rbst_div.sv
// Pipelined signed Q16.16 divider with saturation: (corner - origin) / direction.
// One quotient bit per stage; depends on rbst_pkg.
module rbst_div (
    input  logic                                clk,
    input  logic signed [rbst_pkg::COORD_W-1:0] corner,
    input  logic signed [rbst_pkg::COORD_W-1:0] org,
    input  logic signed [rbst_pkg::COORD_W-1:0] dir,
    output logic signed [rbst_pkg::COORD_W-1:0] quot
);
    import rbst_pkg::*;

    logic [COORD_W:0]   diff;
    logic [COORD_W:0]   diff_mag;
    logic [COORD_W-1:0] dir_mag;

    logic [COORD_W-1:0] rem_reg [0:NUM_W];
    logic [NUM_W-1:0]   nq_reg  [0:NUM_W];
    logic [COORD_W-1:0] den_reg [0:NUM_W];
    logic               neg_reg [0:NUM_W];
    logic [COORD_W-1:0] quot_reg;
    logic [COORD_W-1:0] quot_next;
    logic [NUM_W-1:0]   qmag;

    // Magnitudes and sign of the division.
    always_comb
    begin
        diff     = {corner[COORD_W-1], corner} - {org[COORD_W-1], org};
        diff_mag = diff[COORD_W] ? (~diff + 1'b1) : diff;
        dir_mag  = dir[COORD_W-1] ? (~dir + 1'b1) : dir;
    end

    // Prepare stage.
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= '0;
        nq_reg[0]  <= {diff_mag, 16'b0};
        den_reg[0] <= dir_mag;
        neg_reg[0] <= diff[COORD_W] ^ dir[COORD_W-1];
    end

    // Restoring division, one bit per stage.
    for (genvar i = 0; i < NUM_W; i++) begin : g_stage
        logic [COORD_W:0]   shifted;
        logic [COORD_W+1:0] trial;
        logic               ge;

        always_comb
        begin
            shifted = {rem_reg[i], nq_reg[i][NUM_W-1]};
            trial   = {1'b0, shifted} - {2'b00, den_reg[i]};
            ge      = ~trial[COORD_W+1];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i+1] <= ge ? trial[COORD_W-1:0] : shifted[COORD_W-1:0];
            nq_reg[i+1]  <= {nq_reg[i][NUM_W-2:0], ge};
            den_reg[i+1] <= den_reg[i];
            neg_reg[i+1] <= neg_reg[i];
        end
    end

    // Apply sign and saturate to the Q16.16 range.
    always_comb
    begin
        qmag = nq_reg[NUM_W];
        if (!neg_reg[NUM_W])
        begin
            quot_next = (qmag > {{(NUM_W-COORD_W){1'b0}}, SAT_HI}) ? SAT_HI
                                                                   : qmag[COORD_W-1:0];
        end
        else
        begin
            quot_next = (qmag > {{(NUM_W-COORD_W){1'b0}}, SAT_LO}) ? SAT_LO
                                                                   : (~qmag[COORD_W-1:0] + 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
    end

    assign quot = quot_reg;

endmodule

// File: sv/rbst_axis.sv
// One axis lane: two slab dividers, zero-direction test and entry/exit ordering.
// Depends on rbst_pkg and rbst_div.
module rbst_axis (
    input  logic                                clk,
    input  logic signed [rbst_pkg::COORD_W-1:0] org,
    input  logic signed [rbst_pkg::COORD_W-1:0] dir,
    input  logic signed [rbst_pkg::COORD_W-1:0] lo,
    input  logic signed [rbst_pkg::COORD_W-1:0] hi,
    output rbst_pkg::axis_res_t                 res
);
    import rbst_pkg::*;

    logic signed [COORD_W-1:0] t1;
    logic signed [COORD_W-1:0] t2;
    logic signed [COORD_W-1:0] s_lo;
    logic signed [COORD_W-1:0] s_hi;
    logic                      zero_dir;
    logic                      outside;
    logic                      zero_reg    [0:DIV_LAT-1];
    logic                      outside_reg [0:DIV_LAT-1];
    axis_res_t                 res_reg;
    axis_res_t                 res_next;

    rbst_div u_div_lo (.clk(clk), .corner(lo), .org(org), .dir(dir), .quot(t1));
    rbst_div u_div_hi (.clk(clk), .corner(hi), .org(org), .dir(dir), .quot(t2));

    // Zero-direction slab containment, bounds included.
    always_comb
    begin
        s_lo     = (lo < hi) ? lo : hi;
        s_hi     = (lo < hi) ? hi : lo;
        zero_dir = (dir == '0);
        outside  = zero_dir && ((org < s_lo) || (org > s_hi));
    end

    // Carry the flags alongside the dividers.
    always_ff @(posedge clk)
    begin
        zero_reg[0]    <= zero_dir;
        outside_reg[0] <= outside;
        for (int i = 1; i < DIV_LAT; i++)
        begin
            zero_reg[i]    <= zero_reg[i-1];
            outside_reg[i] <= outside_reg[i-1];
        end
    end

    // Order the two distances into entry and exit.
    always_comb
    begin
        res_next.bounded = ~zero_reg[DIV_LAT-1];
        res_next.outside = outside_reg[DIV_LAT-1];
        res_next.t_entry = (t1 < t2) ? t1 : t2;
        res_next.t_exit  = (t1 < t2) ? t2 : t1;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// File: sv/rbst_merge.sv
// Merge stage: largest entry, smallest exit and the final hit decision.
// Depends on rbst_pkg.
module rbst_merge (
    input  logic                   clk,
    input  rbst_pkg::axis_res_t    res_x,
    input  rbst_pkg::axis_res_t    res_y,
    input  rbst_pkg::axis_res_t    res_z,
    output logic                   hit
);
    import rbst_pkg::*;

    localparam int unsigned T_W = COORD_W + 2;

    axis_res_t               lanes [0:2];
    logic signed [T_W-1:0]   entry_v [0:3];
    logic signed [T_W-1:0]   exit_v  [0:3];
    logic                    any_out;
    logic                    hit_reg;
    logic                    hit_next;

    assign lanes[0] = res_x;
    assign lanes[1] = res_y;
    assign lanes[2] = res_z;

    // Running max of entries and min of exits, unbounded axes skipped.
    always_comb
    begin
        entry_v[0] = -(T_W'(1) <<< COORD_W);
        exit_v[0]  =  (T_W'(1) <<< COORD_W);
        any_out    = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            entry_v[a+1] = entry_v[a];
            exit_v[a+1]  = exit_v[a];
            any_out      = any_out | lanes[a].outside;
            if (lanes[a].bounded)
            begin
                if (T_W'(lanes[a].t_entry) > entry_v[a])
                    entry_v[a+1] = T_W'(lanes[a].t_entry);
                if (T_W'(lanes[a].t_exit) < exit_v[a])
                    exit_v[a+1] = T_W'(lanes[a].t_exit);
            end
        end
        hit_next = !(any_out || (exit_v[3] < 0) || (entry_v[3] > exit_v[3]));
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
    end

    assign hit = hit_reg;

endmodule

// File: sv/ray_box_slab_test_unit.sv
// Ray versus axis-aligned box slab test, top level.
// Depends on rbst_pkg, rbst_axis and rbst_merge.
//
// Usage: a beat is taken each cycle that start is high; busy never rises, so a
// new test may enter every clock cycle. Each test produces one hit result,
// shown with done for exactly one cycle. The latency is set by the three
// axis lanes, each holding two dividers that resolve one quotient bit per
// pipeline stage (49 bits), plus prepare, saturate, ordering and merge
// registers. The receiver cannot stall, and none is needed: results leave
// in order at the rate tests arrive.
module ray_box_slab_test_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [rbst_pkg::COORD_W-1:0] origin_x,
    input  logic signed [rbst_pkg::COORD_W-1:0] origin_y,
    input  logic signed [rbst_pkg::COORD_W-1:0] origin_z,
    input  logic signed [rbst_pkg::COORD_W-1:0] direction_x,
    input  logic signed [rbst_pkg::COORD_W-1:0] direction_y,
    input  logic signed [rbst_pkg::COORD_W-1:0] direction_z,
    input  logic signed [rbst_pkg::COORD_W-1:0] box_min_x,
    input  logic signed [rbst_pkg::COORD_W-1:0] box_min_y,
    input  logic signed [rbst_pkg::COORD_W-1:0] box_min_z,
    input  logic signed [rbst_pkg::COORD_W-1:0] box_max_x,
    input  logic signed [rbst_pkg::COORD_W-1:0] box_max_y,
    input  logic signed [rbst_pkg::COORD_W-1:0] box_max_z,
    output logic                                done,
    output logic                                hit
);
    import rbst_pkg::*;

    axis_res_t res_x;
    axis_res_t res_y;
    axis_res_t res_z;
    logic      vld_reg [0:TOP_LAT-1];

    // The pipeline never stalls.
    assign busy = 1'b0;

    rbst_axis u_axis_x (.clk(clk), .org(origin_x), .dir(direction_x),
                        .lo(box_min_x), .hi(box_max_x), .res(res_x));
    rbst_axis u_axis_y (.clk(clk), .org(origin_y), .dir(direction_y),
                        .lo(box_min_y), .hi(box_max_y), .res(res_y));
    rbst_axis u_axis_z (.clk(clk), .org(origin_z), .dir(direction_z),
                        .lo(box_min_z), .hi(box_max_z), .res(res_z));

    rbst_merge u_merge (.clk(clk), .res_x(res_x), .res_y(res_y), .res_z(res_z), .hit(hit));

    // Valid line that follows each beat through the lanes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOP_LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= start & ~busy;
            for (int i = 1; i < TOP_LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    assign done = vld_reg[TOP_LAT-1];

    // Every result comes from a matching earlier start beat.
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, TOP_LAT))
        else $error("result without a matching start beat");

    // Every start beat yields a result.
    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##TOP_LAT done)
        else $error("start beat produced no result");

    // The block accepts a beat every cycle.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

endmodule
